// File: src/sap_pkg.sv
// Shared types and constants for the stepper angle sequencer.
package sap_pkg;

    localparam int NUM_MOTORS  = 4;
    localparam int MOTOR_IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] COIL_STOP  = 4'hF;
    localparam logic [3:0] COIL_START = 4'h9;

    localparam logic [7:0]  SPA_RESET   = 8'd8;
    localparam logic [15:0] STALL_RESET = 16'd100;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_UNIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_DURATION = 1'd1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_STALL = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         motor_id;
        logic signed [31:0] angle_delta;
        logic               stall_direction;
        logic               end_stop;
    } t_in_item;

    typedef struct packed {
        logic               coil_write;
        logic [3:0]         coil_pattern;
        logic [2:0]         motor_mode;
        logic signed [31:0] remaining_angle;
        logic               move_done;
        logic               end_stop_reached;
        logic               timed_out;
    } t_out_item;

    typedef struct packed {
        t_cmd                   kind;
        logic                   in_range;
        logic [MOTOR_IDX_W-1:0] motor;
        logic signed [31:0]     angle_delta;
        logic                   stall_max;
        logic                   end_stop;
    } t_op;

    typedef struct packed {
        logic [7:0]  steps_per_unit;
        logic [15:0] stall_duration;
    } t_cfg;

endpackage

// File: src/stepper_angle_sequencer_unit.sv
// Top level of the stepper angle sequencer: configuration, front, queue and back.
// An input transfer is registered first in the queue and then in the output register
// before it can appear as an output transfer.
// Throughput: one item per cycle while the output is not stalled; the per-motor read-modify-write in the back sets it.
// A two-entry queue lets input transfers continue while the output is held.
// Synchronous active-low reset: all motors stopped, coil 0x9, counters and angles 0,
// steps per unit 8, stall_duration 100, queue and output empty.
module stepper_angle_sequencer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  sap_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output sap_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [sap_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sap_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    sap_pkg::t_cfg r_cfg;
    sap_pkg::t_op  front_op;
    sap_pkg::t_op  q_op;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps_per_unit <= sap_pkg::SPA_RESET;
            r_cfg.stall_duration <= sap_pkg::STALL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sap_pkg::CFG_STEPS_PER_UNIT: r_cfg.steps_per_unit <= i_cfg_wdata[7:0];
                sap_pkg::CFG_STALL_DURATION: r_cfg.stall_duration <= i_cfg_wdata;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    sap_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_op       (front_op)
    );

    sap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    sap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_op        (q_op),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: src/sap_front.sv
// Front end: accepts input transfers and classifies them into queue operations.
module sap_front (
    input  logic             i_in_valid,
    input  sap_pkg::t_in_item i_in_data,
    input  logic             i_q_full,
    output logic             o_in_stall,
    output logic             o_push,
    output sap_pkg::t_op     o_op
);

    always_comb begin
        o_in_stall       = i_q_full;
        o_push           = i_in_valid && !i_q_full;
        o_op.kind        = sap_pkg::t_cmd'(i_in_data.command);
        o_op.in_range    = ({3'b000, i_in_data.motor_id} < 5'(sap_pkg::NUM_MOTORS));
        o_op.motor       = sap_pkg::MOTOR_IDX_W'(i_in_data.motor_id);
        o_op.angle_delta = i_in_data.angle_delta;
        o_op.stall_max   = i_in_data.stall_direction;
        o_op.end_stop    = i_in_data.end_stop;
    end

endmodule

// File: src/sap_queue.sv
// Short FIFO of classified operations between front and back.
module sap_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  sap_pkg::t_op i_op,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output sap_pkg::t_op o_op
);

    sap_pkg::t_op                r_mem [sap_pkg::QUEUE_DEPTH];
    logic [sap_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [sap_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [sap_pkg::QCNT_W-1:0]  r_count;
    logic [sap_pkg::QPTR_W-1:0]  n_wr_ptr;
    logic [sap_pkg::QPTR_W-1:0]  n_rd_ptr;
    logic [sap_pkg::QCNT_W-1:0]  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == sap_pkg::QPTR_W'(sap_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == sap_pkg::QPTR_W'(sap_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    assign o_full  = (r_count == sap_pkg::QCNT_W'(sap_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

endmodule

// File: src/sap_back.sv
// Back end: per-motor state, command execution and the output register.
module sap_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sap_pkg::t_cfg     i_cfg,
    input  logic              i_q_valid,
    input  sap_pkg::t_op      i_op,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output sap_pkg::t_out_item o_out_data
);

    typedef enum logic [2:0] {
        MODE_STOPPED   = 3'd0,
        MODE_CW        = 3'd1,
        MODE_CCW       = 3'd2,
        MODE_STALL_MIN = 3'd3,
        MODE_STALL_MAX = 3'd4
    } t_mode;

    t_mode              r_mode  [sap_pkg::NUM_MOTORS];
    logic [3:0]         r_phase [sap_pkg::NUM_MOTORS];
    logic [7:0]         r_steps [sap_pkg::NUM_MOTORS];
    logic signed [31:0] r_angle [sap_pkg::NUM_MOTORS];
    logic [15:0]        r_timer [sap_pkg::NUM_MOTORS];

    logic               r_out_valid;
    sap_pkg::t_out_item r_out_data;

    t_mode              cur_mode;
    logic [3:0]         cur_phase;
    logic [7:0]         cur_steps;
    logic signed [31:0] cur_angle;
    logic [15:0]        cur_timer;

    t_mode              n_mode;
    logic [3:0]         n_phase;
    logic [7:0]         n_steps;
    logic signed [31:0] n_angle;
    logic [15:0]        n_timer;
    logic               wrote;
    logic [3:0]         pat;
    logic [3:0]         rot_cw;
    logic [3:0]         rot_ccw;
    logic [7:0]         steps_inc;
    logic signed [32:0] sum;
    sap_pkg::t_out_item n_out_data;

    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        cur_mode  = r_mode[i_op.motor];
        cur_phase = r_phase[i_op.motor];
        cur_steps = r_steps[i_op.motor];
        cur_angle = r_angle[i_op.motor];
        cur_timer = r_timer[i_op.motor];
        rot_cw    = {cur_phase[2:0], cur_phase[3]};
        rot_ccw   = {cur_phase[0], cur_phase[3:1]};
        steps_inc = cur_steps + 8'd1;
        sum       = 33'(cur_angle) + 33'(i_op.angle_delta);

        n_mode  = cur_mode;
        n_phase = cur_phase;
        n_steps = cur_steps;
        n_angle = cur_angle;
        n_timer = cur_timer;
        wrote   = 1'b0;
        pat     = 4'h0;

        unique case (i_op.kind)
            sap_pkg::CMD_TICK: begin
                unique case (cur_mode)
                    MODE_STALL_MIN, MODE_STALL_MAX: begin
                        if (cur_timer == 16'd0) begin
                            n_mode = MODE_STOPPED;
                        end else begin
                            n_phase = (cur_mode == MODE_STALL_MAX) ? rot_cw : rot_ccw;
                            pat     = n_phase;
                            wrote   = 1'b1;
                            n_timer = cur_timer - 16'd1;
                            n_steps = 8'd0;
                        end
                    end
                    MODE_CW, MODE_CCW: begin
                        n_phase = (cur_mode == MODE_CW) ? rot_cw : rot_ccw;
                        pat     = n_phase;
                        wrote   = 1'b1;
                        n_steps = steps_inc;
                        if (steps_inc == i_cfg.steps_per_unit) begin
                            n_steps = 8'd0;
                            if (cur_angle > 0) begin
                                if (cur_mode == MODE_CW) begin
                                    n_angle = cur_angle - 32'sd1;
                                end else begin
                                    n_mode = MODE_CW;
                                end
                            end else if (cur_angle < 0) begin
                                if (cur_mode == MODE_CW) begin
                                    n_mode = MODE_CCW;
                                end else begin
                                    n_angle = cur_angle + 32'sd1;
                                end
                            end else begin
                                n_mode = MODE_STOPPED;
                            end
                        end
                    end
                    MODE_STOPPED: begin
                        pat   = sap_pkg::COIL_STOP;
                        wrote = 1'b1;
                        if (cur_angle > 0) begin
                            n_mode = MODE_CW;
                        end else if (cur_angle < 0) begin
                            n_mode = MODE_CCW;
                        end
                    end
                    default: begin
                        n_mode = MODE_STOPPED;
                    end
                endcase
            end
            sap_pkg::CMD_ADD: begin
                // saturate on overflow
                if (sum[32] != sum[31]) begin
                    n_angle = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    n_angle = sum[31:0];
                end
            end
            sap_pkg::CMD_STALL: begin
                if (cur_timer == 16'd0) begin
                    n_timer = i_cfg.stall_duration;
                    n_mode  = i_op.stall_max ? MODE_STALL_MAX : MODE_STALL_MIN;
                end
            end
            sap_pkg::CMD_STOP: begin
                n_mode  = MODE_STOPPED;
                n_angle = '0;
            end
            default: begin
                n_mode = cur_mode;
            end
        endcase

        if (i_op.in_range) begin
            n_out_data.coil_write       = wrote;
            n_out_data.coil_pattern     = pat;
            n_out_data.motor_mode       = n_mode;
            n_out_data.remaining_angle  = n_angle;
            n_out_data.move_done        = (n_angle == 32'sd0);
            n_out_data.end_stop_reached = i_op.end_stop;
            n_out_data.timed_out        = (n_timer == 16'd0);
        end else begin
            n_out_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sap_pkg::NUM_MOTORS; i++) begin
                r_mode[i]  <= MODE_STOPPED;
                r_phase[i] <= sap_pkg::COIL_START;
                r_steps[i] <= 8'd0;
                r_angle[i] <= '0;
                r_timer[i] <= 16'd0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_op.in_range) begin
                r_mode[i_op.motor]  <= n_mode;
                r_phase[i_op.motor] <= n_phase;
                r_steps[i_op.motor] <= n_steps;
                r_angle[i_op.motor] <= n_angle;
                r_timer[i_op.motor] <= n_timer;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
